### hw/rtl/imu_pkg.sv
// ----------------------------------------------------------------------------
// imu_pkg
// Shared types and constants of the BCD sensor frame decoder.
// ----------------------------------------------------------------------------
package imu_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'h68;
   localparam logic [7:0] SYNC_SECOND = 8'h1f;
   localparam int         BODY_LEN    = 30;
   localparam int         HEADER_LEN  = 2;
   localparam int         FIELD_BYTES = 3;
   localparam int         FIELD_COUNT = 9;
   localparam int         FIELD_SLOTS = 9;
   localparam logic [3:0] NEG_SIGN    = 4'd1;
   localparam logic [3:0] DIGIT_MAX   = 4'd9;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_SYNC2,
      PH_BODY
   } phase_type;

   typedef enum logic [1:0] {
      CMD_HEAD,
      CMD_MID,
      CMD_TAIL
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   field_index;
      logic         last_of_frame;
      logic [7:0]   data_byte;
   } cmd_type;

endpackage

### hw/rtl/imu_req_if.sv
// ----------------------------------------------------------------------------
// imu_req_if
// Input byte channel: valid/ready handshake with one serial data word.
// ----------------------------------------------------------------------------
interface imu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

### hw/rtl/imu_rsp_if.sv
// ----------------------------------------------------------------------------
// imu_rsp_if
// Result channel: valid/ready handshake with one decoded field word.
// ----------------------------------------------------------------------------
interface imu_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         field_index;
   logic signed [17:0] value;
   logic               digit_error;
   logic               last_of_frame;

   modport source (output valid, output field_index, output value,
                   output digit_error, output last_of_frame, input ready);
   modport sink   (input valid, input field_index, input value,
                   input digit_error, input last_of_frame, output ready);
endinterface

### hw/rtl/imu_front.sv
// ----------------------------------------------------------------------------
// imu_front
// Sync hunt and body tracking; turns field bytes into queued commands.
// ----------------------------------------------------------------------------
module imu_front
   import imu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       q_full,
   output logic       q_push,
   output cmd_type    q_cmd
);

   phase_type  phase_ff, phase_in;
   logic [4:0] pos_ff, pos_in;
   logic [1:0] part_ff, part_in;
   logic [3:0] fld_ff, fld_in;

   logic accept;
   logic in_field;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;
   assign in_field = (pos_ff >= 5'(HEADER_LEN)) &&
                     (pos_ff < 5'(HEADER_LEN + FIELD_SLOTS * FIELD_BYTES));

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      part_in  = part_ff;
      fld_in   = fld_ff;
      q_push   = 1'b0;

      q_cmd.data_byte     = in_byte;
      q_cmd.field_index   = fld_ff;
      q_cmd.last_of_frame = (fld_ff == 4'(FIELD_COUNT - 1));
      unique case (part_ff)
         2'd0:    q_cmd.kind = CMD_HEAD;
         2'd1:    q_cmd.kind = CMD_MID;
         default: q_cmd.kind = CMD_TAIL;
      endcase

      if (accept) begin
         unique case (phase_ff)
            PH_SYNC2: begin
               if (in_byte == SYNC_SECOND) begin
                  phase_in = PH_BODY;
                  pos_in   = '0;
                  part_in  = '0;
                  fld_in   = '0;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_BODY: begin
               if (in_field) begin
                  q_push = (fld_ff < 4'(FIELD_COUNT));
                  if (part_ff == 2'(FIELD_BYTES - 1)) begin
                     part_in = '0;
                     fld_in  = fld_ff + 4'd1;
                  end else begin
                     part_in = part_ff + 2'd1;
                  end
               end
               if (pos_ff == 5'(BODY_LEN - 1)) begin
                  phase_in = PH_HUNT;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_ff + 5'd1;
               end
            end
            default: begin
               phase_in = (in_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= '0;
         part_ff  <= '0;
         fld_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         part_ff  <= part_in;
         fld_ff   <= fld_in;
      end
   end

endmodule

### hw/rtl/imu_queue.sv
// ----------------------------------------------------------------------------
// imu_queue
// Short command queue between the front and back halves.
// ----------------------------------------------------------------------------
module imu_queue
   import imu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head_cmd
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_cmd  = entry_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/imu_back.sv
// ----------------------------------------------------------------------------
// imu_back
// BCD accumulation per field and the registered result stage.
// ----------------------------------------------------------------------------
module imu_back
   import imu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  cmd_type           q_cmd,
   output logic              q_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [3:0]        out_field_index,
   output logic signed [17:0] out_value,
   output logic              out_digit_error,
   output logic              out_last_of_frame
);

   logic [16:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic               bad_ff, bad_in;
   logic               valid_ff, valid_in;
   logic [3:0]         fidx_ff;
   logic signed [17:0] value_ff;
   logic               err_ff;
   logic               last_ff;

   logic [3:0]  hi_nib, lo_nib;
   logic        hi_bad, lo_bad;
   logic [23:0] mid_sum;
   logic [17:0] mag_ext;
   logic [17:0] value_calc;
   logic        load_out;

   assign hi_nib  = q_cmd.data_byte[7:4];
   assign lo_nib  = q_cmd.data_byte[3:0];
   assign hi_bad  = (hi_nib > DIGIT_MAX);
   assign lo_bad  = (lo_nib > DIGIT_MAX);
   assign mid_sum = 24'(mag_ff) * 24'd100 + 24'(hi_nib) * 24'd10 + 24'(lo_nib);

   assign q_pop    = q_not_empty && (!valid_ff || out_ready);
   assign load_out = q_pop && (q_cmd.kind == CMD_TAIL);

   always_comb begin
      mag_in = mag_ff;
      neg_in = neg_ff;
      bad_in = bad_ff;
      if (q_pop) begin
         unique case (q_cmd.kind)
            CMD_HEAD: begin
               neg_in = (hi_nib == NEG_SIGN);
               bad_in = lo_bad;
               mag_in = lo_bad ? '0 : 17'(lo_nib);
            end
            CMD_MID, CMD_TAIL: begin
               bad_in = bad_ff || hi_bad || lo_bad;
               mag_in = (bad_ff || hi_bad || lo_bad) ? '0 : mid_sum[16:0];
            end
            default: begin
               mag_in = mag_ff;
            end
         endcase
      end
   end

   assign mag_ext    = bad_in ? '0 : {1'b0, mag_in};
   assign value_calc = neg_in ? (18'd0 - mag_ext) : mag_ext;

   always_comb begin
      valid_in = valid_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (load_out) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         mag_ff   <= '0;
         neg_ff   <= 1'b0;
         bad_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         mag_ff   <= mag_in;
         neg_ff   <= neg_in;
         bad_ff   <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         fidx_ff  <= q_cmd.field_index;
         value_ff <= signed'(value_calc);
         err_ff   <= bad_in;
         last_ff  <= q_cmd.last_of_frame;
      end
   end

   assign out_valid         = valid_ff;
   assign out_field_index   = fidx_ff;
   assign out_value         = value_ff;
   assign out_digit_error   = err_ff;
   assign out_last_of_frame = last_ff;

endmodule

### hw/rtl/imu_bcd_frame_decoder.sv
// ----------------------------------------------------------------------------
// imu_bcd_frame_decoder
// Serial sensor frame parser emitting sign-magnitude BCD fields as integers.
// ----------------------------------------------------------------------------
// One byte word is accepted every clock cycle while the command queue is not
// full. The front tracks the 0x68 0x1f sync pair and the 30-byte body and
// queues each field byte as a command; the back folds the BCD digits and,
// once the third byte of a field leaves the queue, loads a result word into
// the result register. The two-entry command queue and the result register let
// both sides stall on their own: input is held off only when the queue is
// full, which needs a result left waiting.
module imu_bcd_frame_decoder
   import imu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   imu_req_if.sink   req_bus,
   imu_rsp_if.source rsp_bus
);

   logic    q_full;
   logic    q_push;
   cmd_type q_push_cmd;
   logic    q_pop;
   logic    q_not_empty;
   cmd_type q_head_cmd;

   imu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_bus.valid),
      .in_ready (req_bus.ready),
      .in_byte  (req_bus.data_byte),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (q_push_cmd)
   );

   imu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (q_head_cmd)
   );

   imu_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_not_empty       (q_not_empty),
      .q_cmd             (q_head_cmd),
      .q_pop             (q_pop),
      .out_valid         (rsp_bus.valid),
      .out_ready         (rsp_bus.ready),
      .out_field_index   (rsp_bus.field_index),
      .out_value         (rsp_bus.value),
      .out_digit_error   (rsp_bus.digit_error),
      .out_last_of_frame (rsp_bus.last_of_frame)
   );

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the BCD sensor frame decoder.
// ----------------------------------------------------------------------------
// Drives byte words into the decoder and checks every decoded field word
// against the expected words of the directed table or an in-bench model
// of the sync hunt, the body counter and the sign-magnitude BCD fold. A
// short directed sequence covers the sync corner cases, the value extremes,
// odd sign nibbles and bad digits. Random frames follow, mixed with noise
// and broken sync pairs. Both handshakes see random gaps.
// ----------------------------------------------------------------------------
module tb
   import imu_pkg::*;
();

   typedef struct packed {
      logic [3:0]         field_index;
      logic signed [17:0] value;
      logic               digit_error;
      logic               last_of_frame;
   } field_word_type;

   typedef struct packed {
      logic [7:0]     data;
      logic           typed;
      field_word_type want;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_WORDS  = 1500;

   logic clock;
   logic reset;

   imu_req_if req_bus ();
   imu_rsp_if rsp_bus ();

   imu_bcd_frame_decoder dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // decoder model state
   phase_type   hunt_state;
   logic [4:0]  body_pos;
   logic [16:0] mag_acc;
   logic        neg_sign;
   logic        bad_digit;

   field_word_type pending_fields[$];
   int             words_sent;
   int             fields_checked;
   int             bad_fields_seen;
   int             frames_closed;
   int             mismatches;
   bit             calm;

   // sync broken once by a repeated 0x68, a stray 0x1f ignored, then the header and six fields of a body
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'h68, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'h68, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'h1f, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'h68, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'h1f, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'hff, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'h00, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'h19, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'h99, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'h99, 1'b1, '{4'd0, -18'sd99999, 1'b0, 1'b0}},
      '{8'h09, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'h99, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'h99, 1'b1, '{4'd1, 18'sd99999, 1'b0, 1'b0}},
      '{8'h10, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'h00, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'h00, 1'b1, '{4'd2, 18'sd0, 1'b0, 1'b0}},
      '{8'h1a, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'h00, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'h00, 1'b1, '{4'd3, 18'sd0, 1'b1, 1'b0}},
      '{8'hf1, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'h23, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'h45, 1'b1, '{4'd4, 18'sd12345, 1'b0, 1'b0}},
      '{8'h12, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'h3f, 1'b0, '{4'd0, 18'sd0, 1'b0, 1'b0}},
      '{8'h45, 1'b1, '{4'd5, 18'sd0, 1'b1, 1'b0}}
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (calm || r < 70)
         return 0;
      else if (r < 95)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   function automatic void fold_digit(input logic [3:0] nib);
      if (nib > DIGIT_MAX) begin
         bad_digit = 1'b1;
         mag_acc   = '0;
      end else if (!bad_digit) begin
         mag_acc = 17'(mag_acc * 10 + nib);
      end
   endfunction

   // advances the model by one byte; returns 1 when a field word is due
   function automatic bit decode_byte(input logic [7:0] b, output field_word_type fw);
      logic [4:0]  rel;
      logic [3:0]  fld;
      logic [1:0]  part;
      logic [17:0] mag;
      bit          due;
      fw  = '0;
      due = 1'b0;
      case (hunt_state)
         PH_SYNC2: begin
            if (b == SYNC_SECOND) begin
               hunt_state = PH_BODY;
               body_pos   = '0;
            end else begin
               hunt_state = PH_HUNT;
            end
            return 1'b0;
         end
         PH_BODY: ;
         default: begin
            hunt_state = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
            return 1'b0;
         end
      endcase
      if (body_pos >= HEADER_LEN && body_pos < HEADER_LEN + FIELD_SLOTS * FIELD_BYTES) begin
         rel  = 5'(body_pos - HEADER_LEN);
         fld  = 4'(rel / FIELD_BYTES);
         part = 2'(rel % FIELD_BYTES);
         if (part == 0) begin
            neg_sign  = (b[7:4] == NEG_SIGN);
            bad_digit = 1'b0;
            mag_acc   = '0;
            fold_digit(b[3:0]);
         end else begin
            fold_digit(b[7:4]);
            fold_digit(b[3:0]);
         end
         if (part == 2 && fld < FIELD_COUNT) begin
            mag              = bad_digit ? 18'd0 : {1'b0, mag_acc};
            fw.field_index   = fld;
            fw.value         = neg_sign ? -mag : mag;
            fw.digit_error   = bad_digit;
            fw.last_of_frame = (fld == FIELD_COUNT - 1);
            due              = 1'b1;
         end
      end
      if (body_pos + 1 >= BODY_LEN) begin
         hunt_state = PH_HUNT;
         body_pos   = '0;
      end else begin
         body_pos = body_pos + 5'd1;
      end
      return due;
   endfunction

   task automatic send_word(input logic [7:0] b, input bit typed, input field_word_type want);
      int             gap;
      field_word_type fw;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
      if (decode_byte(b, fw))
         pending_fields = {pending_fields, (typed ? want : fw)};
   endtask

   task automatic send_plain(input logic [7:0] b);
      send_word(b, 1'b0, '0);
   endtask

   function automatic logic [3:0] rand_digit();
      return ($urandom_range(99) < 4) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(9));
   endfunction

   task automatic send_frame();
      logic [3:0] sign_nib;
      int         r;
      send_plain(SYNC_FIRST);
      send_plain(SYNC_SECOND);
      send_plain(8'($urandom));
      send_plain(8'($urandom));
      for (int f = 0; f < FIELD_SLOTS; f++) begin
         r = $urandom_range(99);
         sign_nib = (r < 45) ? 4'd0 : (r < 90) ? NEG_SIGN : 4'($urandom);
         send_plain({sign_nib, rand_digit()});
         send_plain({rand_digit(), rand_digit()});
         send_plain({rand_digit(), rand_digit()});
      end
      send_plain(8'($urandom));
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 8);
      repeat (n) send_plain(($urandom_range(3) == 0) ? SYNC_FIRST : 8'($urandom));
   endtask

   task automatic send_broken_sync();
      logic [7:0] b;
      b = ($urandom_range(1) == 0) ? SYNC_FIRST : 8'($urandom);
      if (b == SYNC_SECOND)
         b = 8'h00;
      send_plain(SYNC_FIRST);
      send_plain(b);
   endtask

   // result side: random stalls, check on every accepted word
   initial begin
      int             stall_left;
      field_word_type want;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            fields_checked++;
            if (rsp_bus.digit_error)
               bad_fields_seen++;
            if (rsp_bus.last_of_frame)
               frames_closed++;
            if (pending_fields.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected field word: idx=%0d value=%0d err=%0b last=%0b",
                           rsp_bus.field_index, rsp_bus.value, rsp_bus.digit_error,
                           rsp_bus.last_of_frame);
            end else begin
               want = pending_fields.pop_front();
               if (want.field_index !== rsp_bus.field_index || want.value !== rsp_bus.value ||
                   want.digit_error !== rsp_bus.digit_error ||
                   want.last_of_frame !== rsp_bus.last_of_frame) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("field mismatch: want idx=%0d value=%0d err=%0b last=%0b",
                              want.field_index, want.value, want.digit_error,
                              want.last_of_frame);
                     $display("                 got idx=%0d value=%0d err=%0b last=%0b",
                              rsp_bus.field_index, rsp_bus.value,
                              rsp_bus.digit_error, rsp_bus.last_of_frame);
                  end
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(99) < 15)
               stall_left = pick_gap();
         end
      end
   end

   initial begin
      int  r;
      bit  drained;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= 8'h00;
      hunt_state = PH_HUNT;
      body_pos   = '0;
      mag_acc    = '0;
      neg_sign   = 1'b0;
      bad_digit  = 1'b0;
      calm       = 1'b0;
      drained    = 1'b0;
      words_sent = 0;
      fields_checked = 0;
      bad_fields_seen = 0;
      frames_closed = 0;
      mismatches = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_word(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);

      while (words_sent < DIRECTED_ROWS + RANDOM_WORDS) begin
         if ($urandom_range(9) == 0)
            calm = !calm;
         if (!drained && words_sent > DIRECTED_ROWS + RANDOM_WORDS / 2) begin
            drained = 1'b1;
            req_bus.valid <= 1'b0;
            while (pending_fields.size() != 0) @(posedge clock);
         end
         r = $urandom_range(99);
         if (r < 80)
            send_frame();
         else if (r < 90)
            send_noise();
         else
            send_broken_sync();
      end
      req_bus.valid <= 1'b0;
      while (pending_fields.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d byte words; checked %0d field words", words_sent, fields_checked);
      $display("of which %0d carried bad digits and %0d closed a frame",
               bad_fields_seen, frames_closed);
      if (mismatches == 0 && pending_fields.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/imu_pkg.sv
hw/rtl/imu_req_if.sv
hw/rtl/imu_rsp_if.sv
hw/rtl/imu_front.sv
hw/rtl/imu_queue.sv
hw/rtl/imu_back.sv
hw/rtl/imu_bcd_frame_decoder.sv
tb/sv/tb.sv
